### hdl/lirs_pkg.sv
// ----------------------------------------------------------------------------
// lirs_pkg
// Shared types, constants and sample decode and encode helpers for the linear
// interpolation resampler.
// ----------------------------------------------------------------------------
package lirs_pkg;

  localparam int SampleW = 16;
  localparam int StepW   = 21;
  localparam int PosW    = 21;  // holds frac + step without overflow
  localparam int FracW   = 16;
  localparam int IdxW    = 1;
  localparam int QDepth  = 2;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  localparam logic [StepW-1:0] StepMin   = StepW'(2048);
  localparam logic [StepW-1:0] StepMax   = StepW'(1048576);
  localparam logic [StepW-1:0] StepReset = StepW'(65536);
  localparam logic [PosW-1:0]  PosOne    = PosW'(65536);

  localparam logic [IdxW-1:0] RegStepSize = 1'b0;
  localparam logic [IdxW-1:0] RegWidthMode = 1'b1;

  localparam logic Mode8u  = 1'b0;
  localparam logic Mode16s = 1'b1;

  // one request handed from the front end to the back end
  typedef struct packed {
    logic               single;  // lone sample of a segment, emit as is
    logic               last;
    logic [SampleW-1:0] prev;
    logic [SampleW-1:0] cur;
  } lirs_cmd_t;

  function automatic logic signed [SampleW:0] lirs_decode(
    input logic [SampleW-1:0] raw,
    input logic               mode
  );
    logic signed [SampleW:0] val;
    if (mode == Mode8u) begin
      val = signed'({9'd0, raw[7:0]});
    end else begin
      val = signed'({raw[SampleW-1], raw});
    end
    return val;
  endfunction

  function automatic logic [SampleW-1:0] lirs_encode(
    input logic [SampleW-1:0] val,
    input logic               mode
  );
    logic [SampleW-1:0] res;
    if (mode == Mode8u) begin
      res = {8'd0, val[7:0]};
    end else begin
      res = val;
    end
    return res;
  endfunction

endpackage

### hdl/lirs_front.sv
// ----------------------------------------------------------------------------
// lirs_front
// Accepts input samples, tracks the previous sample of the segment and
// turns each sample into a request for the back end (or just stores it).
// ----------------------------------------------------------------------------
module lirs_front import lirs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SampleW-1:0] in_sample_in,
  input  logic               in_last_in,
  input  logic               q_full,
  output logic               q_push,
  output lirs_cmd_t          q_cmd
);

  logic [SampleW-1:0] prev_r, prev_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic               accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    q_push        = 1'b0;
    q_cmd.single  = !have_prev_r;
    q_cmd.last    = in_last_in;
    q_cmd.prev    = prev_r;
    q_cmd.cur     = in_sample_in;
    if (accept) begin
      if (have_prev_r) begin
        q_push   = 1'b1;
        prev_nxt = in_sample_in;
        if (in_last_in) begin
          have_prev_nxt = 1'b0;
        end
      end else if (in_last_in) begin
        q_push = 1'b1;
      end else begin
        prev_nxt      = in_sample_in;
        have_prev_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else begin
      have_prev_r <= have_prev_nxt;
    end
  end

endmodule

### hdl/lirs_queue.sv
// ----------------------------------------------------------------------------
// lirs_queue
// Small request queue between front end and back end.
// ----------------------------------------------------------------------------
module lirs_queue import lirs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lirs_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output lirs_cmd_t head_cmd
);

  lirs_cmd_t         slot_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]  cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCntW'(QDepth));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### hdl/lirs_back.sv
// ----------------------------------------------------------------------------
// lirs_back
// Walks the read position through each queued interval, one interpolated
// output per cycle unless the output is stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module lirs_back import lirs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [StepW-1:0]   step_size,
  input  logic               width_mode,
  input  logic               head_valid,
  input  lirs_cmd_t          head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SampleW-1:0] out_sample_out,
  output logic               out_last_out
);

  logic [PosW-1:0]    pos_r, pos_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SampleW-1:0] out_sample_r;
  logic               out_last_r;

  logic [StepW-1:0]       step_c;
  logic [PosW-1:0]        pos_adv;
  logic                   in_interval;
  logic signed [SampleW:0]   prev_d, cur_d;
  logic signed [SampleW+1:0] diff_s;
  logic signed [35:0]        prod_s, t_s;
  logic signed [19:0]        q_s;
  logic                   emit, emit_last, fire, slot_free;
  logic [SampleW-1:0]     emit_val;

  always_comb begin
    if (step_size < StepMin) begin
      step_c = StepMin;
    end else if (step_size > StepMax) begin
      step_c = StepMax;
    end else begin
      step_c = step_size;
    end
  end

  assign pos_adv     = pos_r + PosW'(step_c);
  assign in_interval = (pos_r[PosW-1:FracW] == '0);

  // prev + frac*(cur-prev), truncated toward zero
  always_comb begin
    prev_d = lirs_decode(head_cmd.prev, width_mode);
    cur_d  = lirs_decode(head_cmd.cur, width_mode);
    diff_s = (SampleW+2)'(cur_d) - (SampleW+2)'(prev_d);
    prod_s = 36'(diff_s) * 36'(signed'({2'b00, pos_r[FracW-1:0]}));
    t_s    = (36'(prev_d) <<< FracW) + prod_s;
    q_s    = 20'(t_s >>> FracW);
    if (t_s[35] && (t_s[FracW-1:0] != '0)) begin
      q_s = q_s + 20'sd1;
    end
  end

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_val  = lirs_encode(head_cmd.cur, width_mode);
    pop       = 1'b0;
    pos_nxt   = pos_r;
    if (head_cmd.single) begin
      emit      = 1'b1;
      emit_last = 1'b1;
      pop       = 1'b1;
    end else if (in_interval) begin
      emit      = 1'b1;
      emit_val  = lirs_encode(q_s[SampleW-1:0], width_mode);
      emit_last = head_cmd.last && (pos_adv > PosOne);
      pos_nxt   = pos_adv;
    end else begin
      pop = 1'b1;
      if (head_cmd.last) begin
        // landed exactly on the last sample
        emit      = (pos_r == PosOne);
        emit_last = 1'b1;
        pos_nxt   = '0;
      end else begin
        pos_nxt = pos_r - PosOne;
      end
    end
    fire = head_valid && (!emit || slot_free);
    if (!fire) begin
      pop     = 1'b0;
      pos_nxt = pos_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_sample_r <= emit_val;
      out_last_r   <= emit_last;
    end
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_last_out   = out_last_r;

endmodule

### hdl/linear_interp_resampler_top.sv
// Path: an accepted request is written into a queue slot; its first output is
// registered into the output stage when the back end is idle and the stage is free.
// Throughput: one output per cycle while the output stage is not stalled; each
// interval request takes one position-walk step per output plus a closing step.
// Input requests are taken every cycle while the 2-entry queue has room.
// Reset (rst_n low, synchronous) clears position, segment state, queue and
// output valid; step_size returns to 65536 and the mode to 16-bit signed.
// ----------------------------------------------------------------------------
// linear_interp_resampler_top
// Streaming linear interpolation sample rate converter.
// ----------------------------------------------------------------------------
module linear_interp_resampler_top import lirs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IdxW-1:0]    cfg_index,
  input  logic [StepW-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SampleW-1:0] in_sample_in,
  input  logic               in_last_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SampleW-1:0] out_sample_out,
  output logic               out_last_out
);

  logic [StepW-1:0] step_size_r, step_size_nxt;
  logic             width_mode_r, width_mode_nxt;
  logic             q_full, q_push, q_pop, q_head_valid;
  lirs_cmd_t        q_cmd, q_head;

  assign cfg_ready = 1'b1;

  always_comb begin
    step_size_nxt  = step_size_r;
    width_mode_nxt = width_mode_r;
    if (cfg_valid) begin
      case (cfg_index)
        RegStepSize:  step_size_nxt  = cfg_data;
        RegWidthMode: width_mode_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r  <= StepReset;
      width_mode_r <= Mode16s;
    end else begin
      step_size_r  <= step_size_nxt;
      width_mode_r <= width_mode_nxt;
    end
  end

  lirs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample_in (in_sample_in),
    .in_last_in   (in_last_in),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  lirs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head)
  );

  lirs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_size      (step_size_r),
    .width_mode     (width_mode_r),
    .head_valid     (q_head_valid),
    .head_cmd       (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_last_out   (out_last_out)
  );

endmodule

### hdl/lirs_checker.sv
// ----------------------------------------------------------------------------
// lirs_checker
// Port-level checks on the resampler, bound to the top level.
// ----------------------------------------------------------------------------
module lirs_checker import lirs_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic               in_valid,
  input logic               in_ready,
  input logic [SampleW-1:0] in_sample_in,
  input logic               in_last_in,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SampleW-1:0] out_sample_out,
  input logic               out_last_out
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out)
      && $stable(out_last_out))
    else $error("result changed while stalled");

  // a waiting input request holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_sample_in)
      && $stable(in_last_in))
    else $error("input request changed while waiting");

  // reset empties the output stage
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // reset empties the queue, so requests are taken right away
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("in_ready low after reset");

  // configuration writes are always taken
  a_cfg_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration request stalled");

endmodule

bind linear_interp_resampler_top lirs_checker u_lirs_checker (.*);

### dv/tb_linear_interp_resampler_top.sv
// ----------------------------------------------------------------------------
// tb_linear_interp_resampler_top
// Self-checking bench for the linear interpolation resampler. Segments of
// samples go in under many step and width settings. A bit-exact interpolator
// in the bench predicts every output, and each output is checked in order
// against it while both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb_linear_interp_resampler_top;
  import lirs_pkg::*;

  localparam int CycleLimit = 1500000;
  localparam int TotalItems = 210;
  localparam int SettleCyc  = 16;

  typedef struct {
    logic [SampleW-1:0] smp;
    logic               lst;
  } interp_out_t;

  // tracks segment state and turns each accepted sample into the outputs it yields
  class lerp_stream;
    logic [StepW-1:0]   step_reg;
    logic               mode_reg;
    logic [SampleW-1:0] prev_raw;
    logic               have_prev;
    logic [23:0]        rd_pos;
    interp_out_t        pending_outs[$];
    int                 fails;
    int                 outs_seen;

    function new();
      step_reg  = StepReset;
      mode_reg  = Mode16s;
      prev_raw  = '0;
      have_prev = 1'b0;
      rd_pos    = '0;
      fails     = 0;
      outs_seen = 0;
    endfunction

    function void write_reg(logic [IdxW-1:0] idx, logic [StepW-1:0] val);
      case (idx)
        RegStepSize:  step_reg = val;
        RegWidthMode: mode_reg = val[0];
        default: ;
      endcase
    endfunction

    function int to_level(logic [SampleW-1:0] raw, logic m);
      if (m == Mode8u) return int'(raw[7:0]);
      return int'($signed(raw));
    endfunction

    function logic [SampleW-1:0] to_raw(longint v, logic m);
      logic [SampleW-1:0] bits;
      bits = v[SampleW-1:0];
      if (m == Mode8u) bits[15:8] = 8'h00;
      return bits;
    endfunction

    function void take_sample(logic [SampleW-1:0] raw, logic last);
      logic               m;
      int                 cur;
      int                 prv;
      longint             dif;
      longint             acc;
      longint             pl;
      logic [31:0]        pos;
      logic [31:0]        stp;
      logic [SampleW-1:0] vals[$];
      interp_out_t        rec;
      m   = mode_reg;
      cur = to_level(raw, m);
      stp = 32'(step_reg);
      if (stp < 32'(StepMin)) stp = 32'(StepMin);
      if (stp > 32'(StepMax)) stp = 32'(StepMax);
      if (!have_prev) begin
        // opening sample is only stored, unless the segment is this one sample
        if (last) begin
          rec.smp = to_raw(longint'(cur), m);
          rec.lst = 1'b1;
          pending_outs = {pending_outs, rec};
        end else begin
          prev_raw  = raw;
          have_prev = 1'b1;
        end
        rd_pos = '0;
        return;
      end
      prv = to_level(prev_raw, m);
      dif = longint'(cur) - longint'(prv);
      pos = 32'(rd_pos);
      while (pos < 32'(PosOne) && vals.size() < 32) begin
        pl  = pos;
        acc = longint'(prv) * 65536 + pl * dif;
        acc = acc / 65536;  // truncates toward zero
        vals = {vals, to_raw(acc, m)};
        pos = pos + stp;
      end
      pos = (pos >= 32'(PosOne)) ? pos - 32'(PosOne) : 32'd0;
      if (last) begin
        if (pos == 0) vals = {vals, to_raw(longint'(cur), m)};
        have_prev = 1'b0;
        rd_pos    = '0;
      end else begin
        rd_pos = pos[23:0];
      end
      prev_raw = raw;
      foreach (vals[k]) begin
        rec.smp = vals[k];
        rec.lst = last && (k == vals.size() - 1);
        pending_outs = {pending_outs, rec};
      end
    endfunction

    function void match_output(logic [SampleW-1:0] s, logic l);
      interp_out_t want;
      if (pending_outs.size() == 0) begin
        $error("unexpected output: sample_out=%h last_out=%b", s, l);
        fails++;
        return;
      end
      want = pending_outs.pop_front();
      outs_seen++;
      if (s !== want.smp) begin
        $error("sample_out mismatch: expected %h, actual %h", want.smp, s);
        fails++;
      end
      if (l !== want.lst) begin
        $error("last_out mismatch: expected %b, actual %b", want.lst, l);
        fails++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IdxW-1:0]    cfg_index;
  logic [StepW-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [SampleW-1:0] in_sample_in;
  logic               in_last_in;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [SampleW-1:0] out_sample_out;
  logic               out_last_out;

  lerp_stream sb;
  bit         no_gaps;
  int         rdy_hold;
  int         cycles;
  int         items_sent;
  int         seg_count;
  int         cfg_writes;
  int         phase_count;

  linear_interp_resampler_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .in_last_in     (in_last_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_last_out   (out_last_out)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [SampleW-1:0] pick_sample();
    logic [SampleW-1:0] corners[6] = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000,
                                       16'h00FF, 16'h0080};
    if ($urandom_range(0, 9) < 7) return SampleW'($urandom);
    return corners[$urandom_range(0, 5)];
  endfunction

  always @(posedge clk) begin
    int g;
    if (rdy_hold > 0) begin
      rdy_hold  <= rdy_hold - 1;
      out_ready <= 1'b0;
    end else begin
      g = pick_gap();
      out_ready <= (g == 0);
      rdy_hold  <= (g > 0) ? g - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.match_output(out_sample_out, out_last_out);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic feed(input logic [SampleW-1:0] s, input logic l);
    int g;
    in_valid     <= 1'b1;
    in_sample_in <= s;
    in_last_in   <= l;
    do @(posedge clk); while (!in_ready);
    sb.take_sample(s, l);
    items_sent++;
    if (l) seg_count++;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // hold the sender until every predicted output is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_outs.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic put_reg(input logic [IdxW-1:0] idx, input logic [StepW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_writes++;
  endtask

  task automatic set_regs(input logic [StepW-1:0] stp, input logic m);
    logic [StepW-1:0] mode_word;
    mode_word = $urandom_range(0, 1) ? StepW'({$urandom} & ~32'd1) : '0;
    mode_word[0] = m;
    if ($urandom_range(0, 1)) begin
      put_reg(RegStepSize, stp);
      put_reg(RegWidthMode, mode_word);
    end else begin
      put_reg(RegWidthMode, mode_word);
      put_reg(RegStepSize, stp);
    end
    cfg_valid <= 1'b0;
    phase_count++;
  endtask

  function automatic logic [StepW-1:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return StepMin;
      1:       return StepMax;
      2:       return StepW'($urandom_range(0, 2047));
      3:       return StepW'($urandom_range(1048577, 2097151));
      4, 5:    return StepW'($urandom_range(16384, 131072));
      6:       return StepReset;
      7:       return StepW'($urandom_range(2048, 1048576));
      default: return StepW'($urandom_range(32768, 98304));
    endcase
  endfunction

  initial begin
    int n;
    cycles       = 0;
    rdy_hold     = 0;
    no_gaps      = 1'b0;
    items_sent   = 0;
    seg_count    = 0;
    cfg_writes   = 0;
    phase_count  = 0;
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = RegStepSize;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    in_last_in   = 1'b0;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: unity step, 16-bit signed, full-scale swings
    feed(16'h7FFF, 1'b0);
    feed(16'h8000, 1'b0);
    feed(16'h0000, 1'b0);
    feed(16'hFFFF, 1'b1);
    feed(16'h8000, 1'b1);  // lone sample
    settle();

    // step below range clamps to the finest step: 32 per interval, 33 at the end
    set_regs(StepW'(0), Mode8u);
    feed(16'h00FF, 1'b0);
    feed(16'hAB00, 1'b0);
    feed(16'h1201, 1'b1);
    settle();

    // step above range clamps to the coarsest: final sample gets skipped
    set_regs(StepW'(21'h1FFFFF), Mode16s);
    feed(16'h1234, 1'b0);
    feed(16'h5678, 1'b0);
    feed(16'h8001, 1'b0);
    feed(16'h7FFE, 1'b0);
    feed(16'h0F0F, 1'b0);
    feed(16'hF0F0, 1'b1);
    settle();

    // width switch while a segment is open
    set_regs(StepW'(32768), Mode16s);
    feed(16'h4000, 1'b0);
    feed(16'hC000, 1'b0);
    settle();
    set_regs(StepW'(32768), Mode8u);
    feed(16'h0080, 1'b1);
    feed(16'hFF7F, 1'b1);
    settle();

    while (items_sent < TotalItems) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      set_regs(pick_step(), logic'($urandom_range(0, 1)));
      n = $urandom_range(8, 25);
      repeat (n) feed(pick_sample(), logic'($urandom_range(0, 5) == 0));
      settle();  // segment may stay open across the next register change
    end

    no_gaps = 1'b0;
    in_valid <= 1'b0;
    while (sb.pending_outs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d samples (%0d closed segments) over %0d register settings",
             items_sent, seg_count, phase_count);
    $display("Checked %0d outputs after %0d register writes", sb.outs_seen, cfg_writes);
    if (sb.fails == 0 && sb.pending_outs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/lirs_pkg.sv
hdl/lirs_front.sv
hdl/lirs_queue.sv
hdl/lirs_back.sv
hdl/linear_interp_resampler_top.sv
hdl/lirs_checker.sv
dv/tb_linear_interp_resampler_top.sv
